### src/stt_pkg.sv
package stt_pkg;

  localparam int KEYWORD_MAX_BYTES_DEF = 24;
  localparam int COUNTER_BITS_DEF = 24;
  localparam int KW_COUNT = 24;
  localparam int KW_TEXT_MAX = 24;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_COMMENT = 4'd1,
    MODE_NUMBER  = 4'd2,
    MODE_IDENT   = 4'd3,
    MODE_STRING  = 4'd4,
    MODE_ESCAPE  = 4'd5,
    MODE_COLON   = 4'd6,
    MODE_LT      = 4'd7,
    MODE_GT      = 4'd8
  } mode_t;

  localparam logic [5:0] K_UNKNOWN = 6'd0;
  localparam logic [5:0] K_EOF     = 6'd1;
  localparam logic [5:0] K_ASSIGN  = 6'd2;
  localparam logic [5:0] K_NE      = 6'd3;
  localparam logic [5:0] K_LE      = 6'd4;
  localparam logic [5:0] K_GE      = 6'd5;
  localparam logic [5:0] K_EQ      = 6'd6;
  localparam logic [5:0] K_LT      = 6'd7;
  localparam logic [5:0] K_GT      = 6'd8;
  localparam logic [5:0] K_PLUS    = 6'd9;
  localparam logic [5:0] K_MINUS   = 6'd10;
  localparam logic [5:0] K_STAR    = 6'd11;
  localparam logic [5:0] K_SLASH   = 6'd12;
  localparam logic [5:0] K_PCT     = 6'd13;
  localparam logic [5:0] K_LPAR    = 6'd14;
  localparam logic [5:0] K_RPAR    = 6'd15;
  localparam logic [5:0] K_LBRK    = 6'd16;
  localparam logic [5:0] K_RBRK    = 6'd17;
  localparam logic [5:0] K_COMMA   = 6'd18;
  localparam logic [5:0] K_INT     = 6'd19;
  localparam logic [5:0] K_FLOAT   = 6'd20;
  localparam logic [5:0] K_STRING  = 6'd21;
  localparam logic [5:0] K_IDENT   = 6'd22;
  localparam logic [5:0] K_KEYWORD0 = 6'd23;

  // Result record as the back part hands it to the output.
  typedef struct packed {
    logic        record_kind;
    logic [5:0]  token_kind;
    logic [23:0] token_line;
    logic [23:0] start_offset;
    logic [23:0] token_length;
    logic [7:0]  content_byte;
    logic        last_of_run;
  } rec_t;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    logic  eot;
    logic  [7:0] b;
  } req_t;

  localparam logic [4:0] KW_LEN [KW_COUNT] = '{
    5'd6, 5'd6, 5'd6, 5'd10, 5'd14, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd8, 5'd4,
    5'd10, 5'd6, 5'd4, 5'd8, 5'd6, 5'd4, 5'd24, 5'd4, 5'd6, 5'd2, 5'd6, 5'd4};

  // Keyword text, padded with zero bytes; byte 0 is the least significant.
  localparam logic [KW_TEXT_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
    192'hB3D0_BBD0_B0D0,
    192'h87D1_B0D0_BDD0,
    192'hBDD0_BED0_BAD0,
    192'hB4D0_BED0_B2D0_8BD1_B2D0,
    192'h82D1_B0D0_80D1_B2D0_B7D0_BED0_B2D0,
    192'hBBD0_B5D0_86D1,
    192'h89D1_B5D0_B2D0,
    192'h82D1_B8D0_BBD0,
    192'hB3D0_BED0_BBD0,
    192'hB1D0_B0D0_82D1,
    192'hB8D0_BBD0_81D1_B5D0,
    192'hBED0_82D1,
    192'hB5D0_87D1_B0D0_BDD0_B8D0,
    192'hB5D0_81D1_B2D0,
    192'h86D1_BDD0,
    192'hB0D0_BAD0_BED0_BFD0,
    192'hB7D0_B0D0_80D1,
    192'h86D1_BAD0,
    192'h8CD1_82D1_B0D0_B2D0_BED0_B7D0_8CD1_BBD0_BED0_BFD0_81D1_B8D0,
    192'hB0D0_B4D0,
    192'h82D1_B5D0_BDD0,
    192'hB8D0,
    192'hB8D0_BBD0_B8D0,
    192'hB5D0_BDD0};

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_ident_start(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           (b == 8'h5F) || (b > 8'h7F);
  endfunction

endpackage

### src/source_text_tokenizer.sv
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | text_byte, end_of_text
// out_    | output    | out_valid/out_stall | record fields, last_of_run
// cfg_    | input     | cfg_valid/cfg_ready | first_line
// One byte per cycle while the output does not stall: a byte is queued in a
// two-entry queue and handled by the lexer core; each byte yields up to two
// records, drained from a two-slot buffer, which holds off the next byte.
// Reset is synchronous and active low; first_line returns to 1.
// A stall on the output holds the buffer and then fills the input queue.
module source_text_tokenizer #(
  parameter int KEYWORD_MAX_BYTES = stt_pkg::KEYWORD_MAX_BYTES_DEF,
  parameter int COUNTER_BITS = stt_pkg::COUNTER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_kind,
  output logic [5:0]  out_token_kind,
  output logic [23:0] out_token_line,
  output logic [23:0] out_start_offset,
  output logic [23:0] out_token_length,
  output logic [7:0]  out_content_byte,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_first_line
);
  logic [23:0]   first_line_r;
  logic          q_valid, q_take;
  stt_pkg::req_t q_req;
  stt_pkg::rec_t rec;

  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) first_line_r <= 24'd1;
    else if (cfg_valid) first_line_r <= cfg_first_line;
  end

  stt_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_text_byte, .in_end_of_text,
    .q_valid, .q_req, .q_take
  );

  stt_core #(.KEYWORD_MAX_BYTES(KEYWORD_MAX_BYTES), .COUNTER_BITS(COUNTER_BITS)) u_core (
    .clk, .rst_n, .first_line(first_line_r), .q_valid, .q_req, .q_take,
    .out_valid, .out_stall, .out_rec(rec)
  );

  assign out_record_kind  = rec.record_kind;
  assign out_token_kind   = rec.token_kind;
  assign out_token_line   = rec.token_line;
  assign out_start_offset = rec.start_offset;
  assign out_token_length = rec.token_length;
  assign out_content_byte = rec.content_byte;
  assign out_last_of_run  = rec.last_of_run;
endmodule

### src/stt_front.sv
// Front part: takes input requests, marks end of text and queues them in a
// two-entry queue so the lexer core can stall on its own.
module stt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_text_byte,
  input  logic          in_end_of_text,
  output logic          q_valid,
  output stt_pkg::req_t q_req,
  input  logic          q_take
);
  stt_pkg::req_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];

  // Classify: a zero byte counts as end of text.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].eot <= in_end_of_text || (in_text_byte == 8'h00);
      mem_r[wp_r].b   <= in_text_byte;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_take};
    end
  end
endmodule

### src/stt_core.sv
// Back part: lexer state, keyword compare and a two-slot output buffer.
module stt_core #(
  parameter int KEYWORD_MAX_BYTES = stt_pkg::KEYWORD_MAX_BYTES_DEF,
  parameter int COUNTER_BITS = stt_pkg::COUNTER_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [23:0]   first_line,
  input  logic          q_valid,
  input  stt_pkg::req_t q_req,
  output logic          q_take,
  output logic          out_valid,
  input  logic          out_stall,
  output stt_pkg::rec_t out_rec
);
  localparam int CB = COUNTER_BITS;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};
  localparam int WI = $clog2(KEYWORD_MAX_BYTES);
  localparam logic [CB-1:0] KWMAX = CB'(KEYWORD_MAX_BYTES);

  stt_pkg::mode_t mode_r, mode_nxt;
  logic [CB-1:0] line_r, line_nxt, pos_r, pstart_r, pstart_nxt;
  logic [CB-1:0] pline_r, pline_nxt, plen_r, plen_nxt;
  logic          dot_r, dot_nxt, long_r, long_nxt;
  logic [7:0]    word_r [KEYWORD_MAX_BYTES];
  logic          wr_en;
  logic [WI-1:0] wr_idx;

  // Output buffer: up to two records per request.
  stt_pkg::rec_t buf_r [2];
  logic [1:0]    bcnt_r;
  logic          brp_r;
  stt_pkg::rec_t r0, r1;
  logic [1:0]    nres;
  logic          pop;

  logic [7:0] b;
  logic       eot;
  logic [5:0] wkind;
  logic [CB-1:0] linc_line, linc_plen;

  assign b   = q_req.b;
  assign eot = q_req.eot;
  assign pop = out_valid && !out_stall;
  // Take a request only when the buffer has room for two records.
  assign q_take = q_valid && ((bcnt_r == 2'd0) || ((bcnt_r == 2'd1) && pop));
  assign out_valid = (bcnt_r != 2'd0);
  assign out_rec = buf_r[brp_r];

  assign linc_line = (line_r == CMAX) ? CMAX : line_r + 1'b1;
  assign linc_plen = (plen_r == CMAX) ? CMAX : plen_r + 1'b1;

  // Parallel keyword compare against the stored word.
  always_comb begin
    logic hit;
    wkind = stt_pkg::K_IDENT;
    for (int k = stt_pkg::KW_COUNT - 1; k >= 0; k--) begin
      hit = !long_r && (plen_r == CB'(stt_pkg::KW_LEN[k]));
      for (int j = 0; j < stt_pkg::KW_TEXT_MAX; j++) begin
        if (j < int'(stt_pkg::KW_LEN[k]) &&
            word_r[j] != stt_pkg::KW_TEXT[k][j*8 +: 8]) hit = 1'b0;
      end
      if (hit) wkind = stt_pkg::K_KEYWORD0 + 6'(k);
    end
  end

  function automatic stt_pkg::rec_t mk(input logic rk, input logic [5:0] kd,
      input logic [CB-1:0] ln, input logic [CB-1:0] st, input logic [CB-1:0] len,
      input logic [7:0] cb);
    stt_pkg::rec_t r;
    r.record_kind  = rk;
    r.token_kind   = kd;
    r.token_line   = 24'(ln);
    r.start_offset = 24'(st);
    r.token_length = 24'(len);
    r.content_byte = cb;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // Next state and records for one request.
  always_comb begin
    stt_pkg::rec_t pend;
    logic has_pend, fall, emit_pend;
    logic [5:0] ok;
    logic [7:0] d;
    mode_nxt = mode_r; line_nxt = line_r; pstart_nxt = pstart_r;
    pline_nxt = pline_r; plen_nxt = plen_r; dot_nxt = dot_r; long_nxt = long_r;
    wr_en = 1'b0; wr_idx = '0;
    r0 = '0; r1 = '0; nres = 2'd0;
    fall = 1'b0; emit_pend = 1'b0; d = b; ok = '1;
    has_pend = 1'b1;
    pend = '0;
    unique case (mode_r) inside
      stt_pkg::MODE_NUMBER: pend = mk(1'b0, dot_r ? stt_pkg::K_FLOAT : stt_pkg::K_INT,
                                      pline_r, pstart_r, plen_r, 8'h00);
      stt_pkg::MODE_IDENT: pend = mk(1'b0, wkind, pline_r, pstart_r, plen_r, 8'h00);
      stt_pkg::MODE_STRING, stt_pkg::MODE_ESCAPE:
        pend = mk(1'b0, stt_pkg::K_STRING, pline_r, pstart_r, plen_r, 8'h00);
      stt_pkg::MODE_COLON: pend = mk(1'b0, stt_pkg::K_UNKNOWN, pline_r, pstart_r,
                                     CB'(1), 8'h00);
      stt_pkg::MODE_LT: pend = mk(1'b0, stt_pkg::K_LT, pline_r, pstart_r, CB'(1), 8'h00);
      stt_pkg::MODE_GT: pend = mk(1'b0, stt_pkg::K_GT, pline_r, pstart_r, CB'(1), 8'h00);
      default: has_pend = 1'b0;
    endcase

    if (eot) begin
      if (has_pend) begin
        r0 = pend;
        r1 = mk(1'b0, stt_pkg::K_EOF, line_r, pos_r, '0, 8'h00);
        nres = 2'd2;
      end else begin
        r0 = mk(1'b0, stt_pkg::K_EOF, line_r, pos_r, '0, 8'h00);
        nres = 2'd1;
      end
    end else begin
      unique case (mode_r) inside
        stt_pkg::MODE_COMMENT: begin
          if (b == 8'h0A) begin
            line_nxt = linc_line;
            mode_nxt = stt_pkg::MODE_IDLE;
          end
        end
        stt_pkg::MODE_STRING: begin
          if (b == 8'h22) begin
            emit_pend = 1'b1;
            mode_nxt = stt_pkg::MODE_IDLE;
          end else if (b == 8'h5C) begin
            mode_nxt = stt_pkg::MODE_ESCAPE;
          end else begin
            if (b == 8'h0A) line_nxt = linc_line;
            plen_nxt = linc_plen;
            r0 = mk(1'b1, stt_pkg::K_STRING, pline_r, pstart_r, linc_plen, b);
            nres = 2'd1;
          end
        end
        stt_pkg::MODE_ESCAPE: begin
          case (b)
            8'h6E: d = 8'd10;
            8'h72: d = 8'd13;
            8'h74: d = 8'd9;
            8'h65: d = 8'd27;
            default: d = b;
          endcase
          plen_nxt = linc_plen;
          r0 = mk(1'b1, stt_pkg::K_STRING, pline_r, pstart_r, linc_plen, d);
          nres = 2'd1;
          mode_nxt = stt_pkg::MODE_STRING;
        end
        stt_pkg::MODE_NUMBER: begin
          if (stt_pkg::is_digit(b) || b == 8'h2E) begin
            if (b == 8'h2E) dot_nxt = 1'b1;
            plen_nxt = linc_plen;
          end else begin
            emit_pend = 1'b1;
            fall = 1'b1;
          end
        end
        stt_pkg::MODE_IDENT: begin
          if (stt_pkg::is_ident_start(b) || stt_pkg::is_digit(b)) begin
            if (plen_r < KWMAX) begin
              wr_en = 1'b1;
              wr_idx = plen_r[WI-1:0];
            end else begin
              long_nxt = 1'b1;
            end
            plen_nxt = linc_plen;
          end else begin
            emit_pend = 1'b1;
            fall = 1'b1;
          end
        end
        stt_pkg::MODE_COLON, stt_pkg::MODE_LT, stt_pkg::MODE_GT: begin
          if (mode_r == stt_pkg::MODE_COLON && b == 8'h3D) ok = stt_pkg::K_ASSIGN;
          else if (mode_r == stt_pkg::MODE_LT && b == 8'h3E) ok = stt_pkg::K_NE;
          else if (mode_r == stt_pkg::MODE_LT && b == 8'h3D) ok = stt_pkg::K_LE;
          else if (mode_r == stt_pkg::MODE_GT && b == 8'h3D) ok = stt_pkg::K_GE;
          if (ok != '1) begin
            r0 = mk(1'b0, ok, pline_r, pstart_r, CB'(2), 8'h00);
            nres = 2'd1;
            mode_nxt = stt_pkg::MODE_IDLE;
          end else begin
            emit_pend = 1'b1;
            fall = 1'b1;
          end
        end
        default: fall = 1'b1;
      endcase

      if (emit_pend) begin
        r0 = pend;
        nres = 2'd1;
        mode_nxt = stt_pkg::MODE_IDLE;
      end

      // Byte handling from the idle state.
      if (fall) begin
        ok = '1;
        mode_nxt = stt_pkg::MODE_IDLE;
        case (b) inside
          8'h20, 8'h09, 8'h0D: ;
          8'h0A: line_nxt = linc_line;
          8'h7C: mode_nxt = stt_pkg::MODE_COMMENT;
          8'h3A: mode_nxt = stt_pkg::MODE_COLON;
          8'h3C: mode_nxt = stt_pkg::MODE_LT;
          8'h3E: mode_nxt = stt_pkg::MODE_GT;
          8'h22: mode_nxt = stt_pkg::MODE_STRING;
          8'h3D: ok = stt_pkg::K_EQ;
          8'h2B: ok = stt_pkg::K_PLUS;
          8'h2D: ok = stt_pkg::K_MINUS;
          8'h2A: ok = stt_pkg::K_STAR;
          8'h2F: ok = stt_pkg::K_SLASH;
          8'h25: ok = stt_pkg::K_PCT;
          8'h28: ok = stt_pkg::K_LPAR;
          8'h29: ok = stt_pkg::K_RPAR;
          8'h5B: ok = stt_pkg::K_LBRK;
          8'h5D: ok = stt_pkg::K_RBRK;
          8'h2C: ok = stt_pkg::K_COMMA;
          default: begin
            if (stt_pkg::is_digit(b)) mode_nxt = stt_pkg::MODE_NUMBER;
            else if (stt_pkg::is_ident_start(b)) begin
              mode_nxt = stt_pkg::MODE_IDENT;
              wr_en = 1'b1;
              wr_idx = '0;
            end else ok = stt_pkg::K_UNKNOWN;
          end
        endcase
        if (mode_nxt == stt_pkg::MODE_COLON || mode_nxt == stt_pkg::MODE_LT ||
            mode_nxt == stt_pkg::MODE_GT || mode_nxt == stt_pkg::MODE_STRING ||
            mode_nxt == stt_pkg::MODE_NUMBER || mode_nxt == stt_pkg::MODE_IDENT) begin
          pstart_nxt = pos_r;
          pline_nxt = line_r;
          plen_nxt = (mode_nxt == stt_pkg::MODE_STRING) ? '0 : CB'(1);
          dot_nxt = 1'b0;
          long_nxt = 1'b0;
        end
        if (ok != '1) begin
          if (nres == 2'd0) begin
            r0 = mk(1'b0, ok, line_r, pos_r, CB'(1), 8'h00);
            nres = 2'd1;
          end else begin
            r1 = mk(1'b0, ok, line_r, pos_r, CB'(1), 8'h00);
            nres = 2'd2;
          end
        end
      end
    end
    if (nres == 2'd1) r0.last_of_run = 1'b1;
    if (nres == 2'd2) r1.last_of_run = 1'b1;
  end

  // Lexer state registers; end of text restarts everything.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stt_pkg::MODE_IDLE;
      line_r <= CB'(1);
      pos_r <= '0; pstart_r <= '0; pline_r <= '0; plen_r <= '0;
      dot_r <= 1'b0; long_r <= 1'b0;
    end else if (q_take) begin
      if (eot) begin
        mode_r <= stt_pkg::MODE_IDLE;
        line_r <= (CB >= 24) ? CB'(first_line) :
                  ((first_line > 24'(CMAX)) ? CMAX : CB'(first_line));
        pos_r <= '0; pstart_r <= '0; pline_r <= '0; plen_r <= '0;
        dot_r <= 1'b0; long_r <= 1'b0;
      end else begin
        mode_r <= mode_nxt; line_r <= line_nxt;
        pos_r <= (pos_r == CMAX) ? CMAX : pos_r + 1'b1;
        pstart_r <= pstart_nxt; pline_r <= pline_nxt; plen_r <= plen_nxt;
        dot_r <= dot_nxt; long_r <= long_nxt;
      end
    end
  end

  // Word store: registers compared in parallel each cycle.
  always_ff @(posedge clk) begin
    if (q_take && !eot && wr_en) word_r[wr_idx] <= b;
  end

  // Output buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= 2'd0;
      brp_r <= 1'b0;
    end else begin
      if (q_take) begin
        brp_r <= 1'b0;
        bcnt_r <= nres;
      end else if (pop) begin
        brp_r <= 1'b1;
        bcnt_r <= bcnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      buf_r[0] <= r0;
      buf_r[1] <= r1;
    end
  end
endmodule

### src/stt_checker.sv
// Port-level checks for the tokenizer.
module stt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_record_kind,
  input logic [5:0] out_token_kind,
  input logic [7:0] out_content_byte,
  input logic [23:0] out_token_length
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind))
    else $error("stalled output changed");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= (stt_pkg::K_KEYWORD0 + 6'(stt_pkg::KW_COUNT - 1)))
    else $error("token kind out of range");

  a_content_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind |->
      out_token_kind == stt_pkg::K_STRING && out_token_length != 24'd0)
    else $error("content record malformed");

  a_token_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_record_kind |-> out_content_byte == 8'd0)
    else $error("token record carries a byte");

  // The input queue only fills up behind a waiting result.
  a_full_backed: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");
endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_record_kind,
  .out_token_kind, .out_content_byte, .out_token_length
);

### dv/source_text_tokenizer_tb.sv
`timescale 1ns / 100ps

module source_text_tokenizer_tb;

  typedef stt_pkg::rec_t rec_t;
  typedef stt_pkg::mode_t mode_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int FRAGMENTS = 22;
  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = 8'd0;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_record_kind;
  logic [5:0]  out_token_kind;
  logic [23:0] out_token_line;
  logic [23:0] out_start_offset;
  logic [23:0] out_token_length;
  logic [7:0]  out_content_byte;
  logic        out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_first_line = 24'd0;

  source_text_tokenizer u_top (.*);

  always #2 clk = ~clk;

  // Expected records, oldest first, and bookkeeping.
  rec_t token_q[$];
  rec_t step_recs[$];
  int   mismatches = 0;
  int   cycles = 0;
  int   hold_req = 0;
  int   burst_left = 0;

  // Lexer state of the predictor.
  logic [23:0] first_line_reg;
  mode_t       lex_mode;
  logic [23:0] line_cnt, pos_cnt, tok_start, tok_line, tok_len;
  logic        has_dot, word_long;
  logic [7:0]  word_buf [24];

  function automatic logic [23:0] sat_up(input logic [23:0] v);
    return (v == CNT_MAX) ? v : v + 24'd1;
  endfunction

  function automatic logic digit_byte(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic word_byte(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b > 8'd127;
  endfunction

  function void put_rec(input logic rk, input logic [5:0] kind, input logic [23:0] ln,
                        input logic [23:0] st, input logic [23:0] len, input logic [7:0] cb);
    rec_t r;
    r = '{rk, kind, ln, st, len, cb, 1'b0};
    step_recs.push_back(r);
  endfunction

  function void restart_lexer();
    lex_mode = stt_pkg::MODE_IDLE;
    line_cnt = first_line_reg;
    pos_cnt = '0;
    tok_start = '0;
    tok_line = '0;
    tok_len = '0;
    has_dot = 1'b0;
    word_long = 1'b0;
    for (int i = 0; i < 24; i++) word_buf[i] = 8'd0;
  endfunction

  function void open_token(input mode_t m, input logic [23:0] pos);
    lex_mode = m;
    tok_start = pos;
    tok_line = line_cnt;
    tok_len = 24'd1;
    has_dot = 1'b0;
    word_long = 1'b0;
  endfunction

  // Keyword lookup over the stored word bytes.
  function logic [5:0] word_kind();
    logic hit;
    if (word_long) return stt_pkg::K_IDENT;
    for (int k = 0; k < stt_pkg::KW_COUNT; k++) begin
      if (tok_len == 24'(stt_pkg::KW_LEN[k])) begin
        hit = 1'b1;
        for (int i = 0; i < int'(stt_pkg::KW_LEN[k]); i++)
          if (word_buf[i] != stt_pkg::KW_TEXT[k][8*i +: 8]) hit = 1'b0;
        if (hit) return stt_pkg::K_KEYWORD0 + 6'(k);
      end
    end
    return stt_pkg::K_IDENT;
  endfunction

  function void flush_pending();
    case (lex_mode)
      stt_pkg::MODE_NUMBER:
        put_rec(1'b0, has_dot ? stt_pkg::K_FLOAT : stt_pkg::K_INT, tok_line, tok_start,
                tok_len, 8'd0);
      stt_pkg::MODE_IDENT: put_rec(1'b0, word_kind(), tok_line, tok_start, tok_len, 8'd0);
      stt_pkg::MODE_STRING, stt_pkg::MODE_ESCAPE:
        put_rec(1'b0, stt_pkg::K_STRING, tok_line, tok_start, tok_len, 8'd0);
      stt_pkg::MODE_COLON:
        put_rec(1'b0, stt_pkg::K_UNKNOWN, tok_line, tok_start, 24'd1, 8'd0);
      stt_pkg::MODE_LT: put_rec(1'b0, stt_pkg::K_LT, tok_line, tok_start, 24'd1, 8'd0);
      stt_pkg::MODE_GT: put_rec(1'b0, stt_pkg::K_GT, tok_line, tok_start, 24'd1, 8'd0);
      default: ;
    endcase
    lex_mode = stt_pkg::MODE_IDLE;
  endfunction

  // Handling of a byte that arrives between tokens.
  function void idle_byte(input logic [7:0] b, input logic [23:0] pos);
    logic [5:0] k;
    logic single;
    single = 1'b1;
    k = stt_pkg::K_UNKNOWN;
    case (b)
      " ", 8'd9, 8'd13: return;
      8'd10: begin
        line_cnt = sat_up(line_cnt);
        return;
      end
      "|": begin
        lex_mode = stt_pkg::MODE_COMMENT;
        return;
      end
      ":": begin
        open_token(stt_pkg::MODE_COLON, pos);
        return;
      end
      "<": begin
        open_token(stt_pkg::MODE_LT, pos);
        return;
      end
      ">": begin
        open_token(stt_pkg::MODE_GT, pos);
        return;
      end
      "\"": begin
        open_token(stt_pkg::MODE_STRING, pos);
        tok_len = '0;
        return;
      end
      "=": k = stt_pkg::K_EQ;
      "+": k = stt_pkg::K_PLUS;
      "-": k = stt_pkg::K_MINUS;
      "*": k = stt_pkg::K_STAR;
      "/": k = stt_pkg::K_SLASH;
      "%": k = stt_pkg::K_PCT;
      "(": k = stt_pkg::K_LPAR;
      ")": k = stt_pkg::K_RPAR;
      "[": k = stt_pkg::K_LBRK;
      "]": k = stt_pkg::K_RBRK;
      ",": k = stt_pkg::K_COMMA;
      default: single = 1'b0;
    endcase
    if (single) put_rec(1'b0, k, line_cnt, pos, 24'd1, 8'd0);
    else if (digit_byte(b)) open_token(stt_pkg::MODE_NUMBER, pos);
    else if (word_byte(b)) begin
      open_token(stt_pkg::MODE_IDENT, pos);
      word_buf[0] = b;
    end else put_rec(1'b0, stt_pkg::K_UNKNOWN, line_cnt, pos, 24'd1, 8'd0);
  endfunction

  // Computes the records caused by one accepted request into step_recs.
  function void lex_byte(input logic [7:0] b, input logic eot);
    logic fall;
    logic [7:0] d;
    logic [5:0] k;
    logic [23:0] pos;
    step_recs.delete();
    fall = 1'b0;
    pos = pos_cnt;
    if (eot || b == 8'd0) begin
      flush_pending();
      put_rec(1'b0, stt_pkg::K_EOF, line_cnt, pos_cnt, 24'd0, 8'd0);
      restart_lexer();
    end else begin
      case (lex_mode)
        stt_pkg::MODE_COMMENT: if (b == 8'd10) begin
          line_cnt = sat_up(line_cnt);
          lex_mode = stt_pkg::MODE_IDLE;
        end
        stt_pkg::MODE_STRING: begin
          if (b == "\"") flush_pending();
          else if (b == "\\") lex_mode = stt_pkg::MODE_ESCAPE;
          else begin
            if (b == 8'd10) line_cnt = sat_up(line_cnt);
            tok_len = sat_up(tok_len);
            put_rec(1'b1, stt_pkg::K_STRING, tok_line, tok_start, tok_len, b);
          end
        end
        stt_pkg::MODE_ESCAPE: begin
          case (b)
            "n": d = 8'd10;
            "r": d = 8'd13;
            "t": d = 8'd9;
            "e": d = 8'd27;
            default: d = b;
          endcase
          tok_len = sat_up(tok_len);
          put_rec(1'b1, stt_pkg::K_STRING, tok_line, tok_start, tok_len, d);
          lex_mode = stt_pkg::MODE_STRING;
        end
        stt_pkg::MODE_NUMBER: begin
          if (digit_byte(b) || b == ".") begin
            if (b == ".") has_dot = 1'b1;
            tok_len = sat_up(tok_len);
          end else begin
            flush_pending();
            fall = 1'b1;
          end
        end
        stt_pkg::MODE_IDENT: begin
          if (word_byte(b) || digit_byte(b)) begin
            if (tok_len < 24'd24) word_buf[tok_len] = b;
            else word_long = 1'b1;
            tok_len = sat_up(tok_len);
          end else begin
            flush_pending();
            fall = 1'b1;
          end
        end
        stt_pkg::MODE_COLON, stt_pkg::MODE_LT, stt_pkg::MODE_GT: begin
          k = stt_pkg::K_UNKNOWN;
          if (lex_mode == stt_pkg::MODE_COLON && b == "=") k = stt_pkg::K_ASSIGN;
          else if (lex_mode == stt_pkg::MODE_LT && b == ">") k = stt_pkg::K_NE;
          else if (lex_mode == stt_pkg::MODE_LT && b == "=") k = stt_pkg::K_LE;
          else if (lex_mode == stt_pkg::MODE_GT && b == "=") k = stt_pkg::K_GE;
          if (k != stt_pkg::K_UNKNOWN) begin
            put_rec(1'b0, k, tok_line, tok_start, 24'd2, 8'd0);
            lex_mode = stt_pkg::MODE_IDLE;
          end else begin
            flush_pending();
            fall = 1'b1;
          end
        end
        default: begin
          lex_mode = stt_pkg::MODE_IDLE;
          fall = 1'b1;
        end
      endcase
      if (fall) idle_byte(b, pos);
      pos_cnt = sat_up(pos_cnt);
    end
    if (step_recs.size() > 0) step_recs[step_recs.size()-1].last_of_run = 1'b1;
  endfunction

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Sends one request in bursts with random gaps; predicts on acceptance.
  task automatic send_byte(input logic [7:0] b, input logic eot,
                           input logic fixed = 1'b0, input rec_t want = '0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    lex_byte(b, eot);
    if (fixed) token_q.push_back(want);
    else foreach (step_recs[i]) token_q.push_back(step_recs[i]);
  endtask

  // Sender pauses until every expected record has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (token_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_first_line(input logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_first_line <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    first_line_reg = v;
  endtask

  // One lexical fragment of random content, mostly well formed.
  task automatic send_fragment();
    int sel, n, k;
    logic [7:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 18) begin
      k = $urandom_range(0, stt_pkg::KW_COUNT - 1);
      for (int i = 0; i < int'(stt_pkg::KW_LEN[k]); i++)
        send_byte(stt_pkg::KW_TEXT[k][8*i +: 8], 1'b0);
      if ($urandom_range(0, 3) == 0) send_byte(8'h80 + 8'($urandom_range(0, 127)), 1'b0);
    end else if (sel < 30) begin
      n = $urandom_range(1, 8);
      send_byte("a" + 8'($urandom_range(0, 25)), 1'b0);
      for (int i = 1; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: c = "0" + 8'($urandom_range(0, 9));
          1: c = "_";
          2: c = 8'($urandom_range(128, 255));
          default: c = "A" + 8'($urandom_range(0, 25));
        endcase
        send_byte(c, 1'b0);
      end
    end else if (sel < 33) begin
      // Words past the keyword store, each starting with the longest keyword.
      n = $urandom_range(25, 30);
      k = 18;
      for (int i = 0; i < n; i++)
        send_byte(i < 24 ? stt_pkg::KW_TEXT[k][8*i +: 8] : "x", 1'b0);
    end else if (sel < 45) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        send_byte(($urandom_range(0, 4) == 0) ? "." : "0" + 8'($urandom_range(0, 9)), 1'b0);
    end else if (sel < 60) begin
      case ($urandom_range(0, 3))
        0: c = ":";
        1: c = "<";
        2: c = ">";
        default: c = "=";
      endcase
      send_byte(c, 1'b0);
      case ($urandom_range(0, 5))
        0: send_byte("=", 1'b0);
        1: send_byte(">", 1'b0);
        2: send_byte("(", 1'b0);
        3: send_byte(",", 1'b0);
        default: ;
      endcase
    end else if (sel < 72) begin
      send_byte("\"", 1'b0);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_byte("\\", 1'b0);
          case ($urandom_range(0, 7))
            0: c = "n";
            1: c = "r";
            2: c = "t";
            3: c = "e";
            4: c = "\"";
            5: c = "\\";
            default: c = 8'($urandom_range(1, 255));
          endcase
        end else c = 8'($urandom_range(1, 255));
        if (c == "\"" && $urandom_range(0, 1) == 0) c = "q";
        send_byte(c, 1'b0);
      end
      if ($urandom_range(0, 7) != 0) send_byte("\"", 1'b0);
    end else if (sel < 78) begin
      send_byte("|", 1'b0);
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(1, 255)), 1'b0);
      send_byte(8'd10, 1'b0);
    end else if (sel < 88) begin
      case ($urandom_range(0, 3))
        0: c = " ";
        1: c = 8'd9;
        2: c = 8'd13;
        default: c = 8'd10;
      endcase
      send_byte(c, 1'b0);
    end else if (sel < 97) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Directed rows; the first ones carry their expected record.
  typedef struct {
    logic [7:0] b;
    logic       eot;
    logic       fixed;
    rec_t       want;
  } row_t;

  localparam int DIR_ROWS = 24;
  row_t dir_rows [DIR_ROWS] = '{
    '{8'hFF, 1'b1, 1'b1, '{1'b0, stt_pkg::K_EOF, 24'd1, 24'd0, 24'd0, 8'd0, 1'b1}},
    '{"(", 1'b0, 1'b1, '{1'b0, stt_pkg::K_LPAR, 24'd1, 24'd0, 24'd1, 8'd0, 1'b1}},
    '{"\\", 1'b0, 1'b1, '{1'b0, stt_pkg::K_UNKNOWN, 24'd1, 24'd1, 24'd1, 8'd0, 1'b1}},
    '{":", 1'b0, 1'b0, '0}, '{"=", 1'b0, 1'b0, '0},
    '{"<", 1'b0, 1'b0, '0}, '{">", 1'b0, 1'b0, '0},
    '{">", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0},
    '{".", 1'b0, 1'b0, '0}, '{".", 1'b0, 1'b0, '0},
    '{"\"", 1'b0, 1'b0, '0}, '{"\\", 1'b0, 1'b0, '0},
    '{"e", 1'b0, 1'b0, '0}, '{8'd10, 1'b0, 1'b0, '0},
    '{"\"", 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{"|", 1'b0, 1'b0, '0}, '{"x", 1'b0, 1'b0, '0},
    '{8'd10, 1'b0, 1'b0, '0}, '{":", 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b0, '0}, '{"\"", 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0}
  };

  // Receiver stall pattern, with one long hold-off in the second random phase.
  int stall_pct = 0;
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (cycles % 128 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    rec_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_record_kind, out_token_kind, out_token_line, out_start_offset,
              out_token_length, out_content_byte, out_last_of_run};
      if (token_q.size() == 0) begin
        report($sformatf("unexpected record kind %0d", got.token_kind));
      end else begin
        want = token_q.pop_front();
        if (got !== want)
          report($sformatf({"rk %0d/%0d kind %0d/%0d line %0h/%0h start %0h/%0h ",
                            "len %0h/%0h byte %0h/%0h last %0d/%0d"},
                           got.record_kind, want.record_kind, got.token_kind,
                           want.token_kind, got.token_line, want.token_line,
                           got.start_offset, want.start_offset, got.token_length,
                           want.token_length, got.content_byte, want.content_byte,
                           got.last_of_run, want.last_of_run));
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("source_text_tokenizer_tb: FAIL");
      $finish;
    end
  end

  // Main sequence: reset, directed rows, then random phases at several line bases.
  initial begin
    logic [23:0] bases [5];
    first_line_reg = 24'd1;
    restart_lexer();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].eot, dir_rows[i].fixed, dir_rows[i].want);
    wait_drained();

    bases = '{24'd0, CNT_MAX, 24'($urandom), 24'hFFFFFE, 24'd1};
    foreach (bases[p]) begin
      write_first_line(bases[p]);
      send_byte(8'd0, 1'b1);
      if (p == 1) hold_req++;
      for (int n = 0; n < FRAGMENTS; n++) send_fragment();
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("source_text_tokenizer_tb: PASS");
    else $display("source_text_tokenizer_tb: FAIL");
    $finish;
  end

endmodule

### filelist.f
src/stt_pkg.sv
src/stt_front.sv
src/stt_core.sv
src/source_text_tokenizer.sv
src/stt_checker.sv
dv/source_text_tokenizer_tb.sv
